FILE: rtl/core/cspan_pkg.sv
// ----------------------------------------------------------------------------
// cspan_pkg: shared types and constants of the CIGAR span parser
// Character codes, run length width and the parser state and result records.
// ----------------------------------------------------------------------------
package cspan_pkg;

	// Width of the pending run length; digit runs saturate at its maximum.
	localparam int LEN_BITS = 28;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_M  = 8'h4D;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_X  = 8'h58;
	localparam logic [7:0] CH_S  = 8'h53;
	localparam logic [7:0] CH_H  = 8'h48;
	localparam logic [7:0] CH_I  = 8'h49;
	localparam logic [7:0] CH_D  = 8'h44;
	localparam logic [7:0] CH_N  = 8'h4E;

	typedef struct packed {
		logic [LEN_BITS-1:0] run;
		logic [31:0]         read_lo;
		logic [31:0]         read_hi;
		logic [31:0]         ref_lo;
		logic [31:0]         ref_hi;
		logic                match_seen;
		logic                strand;
		logic [30:0]         length;
		logic                at_start;
	} span_state_t;

	typedef struct packed {
		logic [31:0] read_begin;
		logic [31:0] read_finish;
		logic [30:0] ref_begin;
		logic [31:0] ref_finish;
	} span_result_t;

endpackage

FILE: rtl/core/cspan_step.sv
// ----------------------------------------------------------------------------
// cspan_step: next-state and result logic for one CIGAR character
// Opens a new string when needed, folds in a digit or applies an operation.
// ----------------------------------------------------------------------------
module cspan_step import cspan_pkg::*; (
	input  span_state_t  cur,
	input  logic [7:0]   cigar_char,
	input  logic         last_char,
	input  logic [30:0]  ref_start,
	input  logic         strand_same,
	input  logic [30:0]  read_length,
	output span_state_t  nxt,
	output span_result_t res
);

	always_comb begin
		span_state_t         base;
		logic [LEN_BITS+3:0] prod;
		logic [31:0]         num;

		base = cur;
		if (cur.at_start) begin
			base.strand     = strand_same;
			base.length     = read_length;
			base.read_lo    = '0;
			base.read_hi    = '1;
			base.ref_lo     = {1'b0, ref_start};
			base.ref_hi     = {1'b0, ref_start} - 32'd1;
			base.match_seen = 1'b0;
			base.run        = '0;
		end

		nxt          = base;
		nxt.at_start = last_char;

		// Times ten as two shifted copies, plus the digit from the low nibble.
		prod = {1'b0, base.run, 3'b000} + {3'b000, base.run, 1'b0}
			+ {{LEN_BITS{1'b0}}, cigar_char[3:0]};
		num  = {{(32-LEN_BITS){1'b0}}, base.run};

		if (cigar_char inside {[CH_0:CH_9]}) begin
			nxt.run = (prod > {4'b0000, LEN_MAX}) ? LEN_MAX : prod[LEN_BITS-1:0];
		end else begin
			nxt.run = '0;
			case (cigar_char)
				CH_M, CH_EQ, CH_X: begin
					nxt.read_hi    = base.read_hi + num;
					nxt.ref_hi     = base.ref_hi + num;
					nxt.match_seen = 1'b1;
				end
				CH_S, CH_H: begin
					// Clipping only moves the read window ahead of the first match.
					if (!base.match_seen) begin
						nxt.read_lo = base.read_lo + num;
						nxt.read_hi = base.read_hi + num;
					end
				end
				CH_I: begin
					nxt.read_hi = base.read_hi + num;
				end
				CH_D, CH_N: begin
					nxt.ref_hi = base.ref_hi + num;
				end
				default: begin
				end
			endcase
		end

		if (nxt.strand) begin
			res.read_begin  = nxt.read_lo;
			res.read_finish = nxt.read_hi;
		end else begin
			res.read_begin  = {1'b0, nxt.length} - nxt.read_hi - 32'd1;
			res.read_finish = {1'b0, nxt.length} - nxt.read_lo - 32'd1;
		end
		res.ref_begin  = nxt.ref_lo[30:0];
		res.ref_finish = nxt.ref_hi;
	end

endmodule

FILE: rtl/core/cigar_span_parser.sv
// ----------------------------------------------------------------------------
// cigar_span_parser: read and reference span of a CIGAR string
// Streams CIGAR characters in and gives one span word per string.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries one ASCII character of a CIGAR string; s_tlast
// marks the final character. The reference start, strand flag and read
// length are taken from the first word of each string and ignored later.
// For every word with s_tlast set, one output word appears on the master
// side with the read start and end (flipped against the read length when
// the strands differ) and the inclusive reference start and end.
// Throughput is one character per cycle, except while a final character
// waits as described below. An accepted word is captured in the input
// register; the step logic then processes it and, for a final character,
// loads the result register, from which m_tvalid is driven.
// When the receiver stalls, the input keeps flowing for characters that
// give no result; only a final character that finds the output register
// still full waits in the input register, and s_tready drops until the
// output word is taken.
// Reset clears both stages and returns the parser to the start of a string.
// ----------------------------------------------------------------------------
module cigar_span_parser import cspan_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// Fields from bit 0: cigar_char[7:0], ref_start[38:8], strand_same[39],
	// read_length[70:40], zero fill[71].
	input  logic [71:0]  s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// Fields from bit 0: read_begin[31:0], read_finish[63:32],
	// ref_begin[94:64], ref_finish[126:95], zero fill[127].
	output logic [127:0] m_tdata
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;
	logic [30:0]  ref_start_s1;
	logic         strand_s1;
	logic [30:0]  length_s1;

	span_state_t  state_q;
	span_state_t  state_next;
	span_result_t res_next;
	span_result_t res_q;
	logic         out_valid_q;
	logic         go_s1;

	// A character that yields no result always moves on; a final one needs
	// the output register to be free or emptied in this cycle.
	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1      <= s_tdata[7:0];
			ref_start_s1 <= s_tdata[38:8];
			strand_s1    <= s_tdata[39];
			length_s1    <= s_tdata[70:40];
			last_s1      <= s_tlast;
		end
	end

	cspan_step u_step (
		.cur         (state_q),
		.cigar_char  (char_s1),
		.last_char   (last_s1),
		.ref_start   (ref_start_s1),
		.strand_same (strand_s1),
		.read_length (length_s1),
		.nxt         (state_next),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.run        <= '0;
			state_q.read_lo    <= '0;
			state_q.read_hi    <= '1;
			state_q.ref_lo     <= '0;
			state_q.ref_hi     <= '0;
			state_q.match_seen <= 1'b0;
			state_q.strand     <= 1'b0;
			state_q.length     <= '0;
			state_q.at_start   <= 1'b1;
			out_valid_q        <= 1'b0;
		end else begin
			if (go_s1) begin
				state_q <= state_next;
			end
			if (go_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.ref_finish, res_q.ref_begin,
		res_q.read_finish, res_q.read_begin};

endmodule

FILE: rtl/core/cspan_checker.sv
// ----------------------------------------------------------------------------
// cspan_checker: port-level checks for the CIGAR span parser
// Watches the stream ports for stalls, held words and result delivery.
// ----------------------------------------------------------------------------
module cspan_checker import cspan_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [71:0]  s_tdata,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	// A stalled output word stays put until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// The input side only stalls behind a waiting output word.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// An accepted final character leads to a valid output word.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
		else $error("no output word after final character");

	// The fill bit above the result fields stays clear.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[127])
		else $error("fill bit of output word set");

endmodule

bind cigar_span_parser cspan_checker u_cspan_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cigar_span_parser
// Streams directed and random CIGAR strings into the parser, predicts the
// read and reference span of every string and compares each output word
// field by field, with random idling on both the sender and receiver side.
// ----------------------------------------------------------------------------
module tb;
	import cspan_pkg::*;

	// One character word as it is queued for the sender.
	typedef struct {
		logic [7:0]  ch;
		logic        last;
		logic [30:0] ref_start;
		logic        strand;
		logic [30:0] rlen;
	} cig_char_t;

	// One span word as the receiver expects it.
	typedef struct {
		logic [31:0] rd_begin;
		logic [31:0] rd_finish;
		logic [30:0] rf_begin;
		logic [31:0] rf_finish;
	} span_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;

	cigar_span_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cig_char_t char_q[$];
	span_t     span_q[$];
	cig_char_t cur;
	int        failures = 0;
	int        cyc = 0;
	logic      steady;

	// Fields for the first word of the string being built; later words of the
	// same string carry random values that the parser has to ignore.
	logic [30:0] str_ref;
	logic        str_strand;
	logic [30:0] str_len;
	logic        str_open = 1'b0;

	// Predicted parser state.
	logic [LEN_BITS-1:0] cig_run;
	logic [31:0]         rd_lo;
	logic [31:0]         rd_hi;
	logic [31:0]         rf_lo;
	logic [31:0]         rf_hi;
	logic                matched;
	logic                pred_strand;
	logic [30:0]         rd_len;
	logic                new_string = 1'b1;

	// Both sides run without any idling through this window of cycles.
	always @(posedge clk) cyc <= cyc + 1;
	assign steady = (cyc >= 300) && (cyc < 700);

	function automatic logic [30:0] rand31();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(9))
			0, 1, 2: return CH_M;
			3: return CH_EQ;
			4: return CH_X;
			5: return CH_S;
			6: return CH_H;
			7: return CH_I;
			8: return CH_D;
			default: return CH_N;
		endcase
	endfunction

	function automatic void add_char(input logic [7:0] ch, input logic last);
		cig_char_t c;
		c.ch = ch;
		c.last = last;
		if (!str_open) begin
			c.ref_start = str_ref;
			c.strand = str_strand;
			c.rlen = str_len;
			str_open = 1'b1;
		end else begin
			c.ref_start = rand31();
			c.strand = 1'($urandom);
			c.rlen = rand31();
		end
		if (last)
			str_open = 1'b0;
		char_q.push_back(c);
	endfunction

	function automatic void push_string(input string s, input logic closes);
		for (int i = 0; i < s.len(); i++)
			add_char(s.getc(i), closes && (i == s.len() - 1));
	endfunction

	// Applies one accepted character to the predicted state and queues the
	// expected span word when the character closes its string.
	function automatic void span_step(input cig_char_t it);
		logic [35:0] prod;
		logic [31:0] num;
		span_t       e;
		if (new_string) begin
			pred_strand = it.strand;
			rd_len = it.rlen;
			rd_lo = '0;
			rd_hi = '1;
			rf_lo = {1'b0, it.ref_start};
			rf_hi = rf_lo - 32'd1;
			matched = 1'b0;
			cig_run = '0;
			new_string = 1'b0;
		end
		if (it.ch >= CH_0 && it.ch <= CH_9) begin
			prod = 36'(cig_run) * 36'd10 + 36'(it.ch - CH_0);
			cig_run = (prod > 36'(LEN_MAX)) ? LEN_MAX : prod[LEN_BITS-1:0];
		end else begin
			num = 32'(cig_run);
			cig_run = '0;
			case (it.ch)
				CH_M, CH_EQ, CH_X: begin
					rd_hi = rd_hi + num;
					rf_hi = rf_hi + num;
					matched = 1'b1;
				end
				// Clipping only moves the read window before the first match.
				CH_S, CH_H: begin
					if (!matched) begin
						rd_lo = rd_lo + num;
						rd_hi = rd_hi + num;
					end
				end
				CH_I: rd_hi = rd_hi + num;
				CH_D, CH_N: rf_hi = rf_hi + num;
				default: ;
			endcase
		end
		if (it.last) begin
			if (pred_strand) begin
				e.rd_begin = rd_lo;
				e.rd_finish = rd_hi;
			end else begin
				e.rd_begin = {1'b0, rd_len} - rd_hi - 32'd1;
				e.rd_finish = {1'b0, rd_len} - rd_lo - 32'd1;
			end
			e.rf_begin = rf_lo[30:0];
			e.rf_finish = rf_hi;
			span_q.push_back(e);
			new_string = 1'b1;
		end
	endfunction

	// Sender: predicts on every accepted word, then loads the next one.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				span_step(cur);
			if (!s_tvalid || s_tready) begin
				if (char_q.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
					cur = char_q.pop_front();
					s_tdata <= {1'b0, cur.rlen, cur.strand, cur.ref_start, cur.ch};
					s_tlast <= cur.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			failures++;
		end
	endtask

	// Receiver: compares every accepted span word with the oldest prediction.
	always @(posedge clk) begin
		span_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (span_q.size() == 0) begin
					$display("%0t: unexpected output word, actual %h", $time, m_tdata);
					failures++;
				end else begin
					e = span_q.pop_front();
					check_field("read_begin", e.rd_begin, m_tdata[31:0]);
					check_field("read_finish", e.rd_finish, m_tdata[63:32]);
					check_field("ref_begin", {1'b0, e.rf_begin}, {1'b0, m_tdata[94:64]});
					check_field("ref_finish", e.rf_finish, m_tdata[126:95]);
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 6);
		end
	end

	initial begin
		logic [7:0] body[$];
		int         nops;
		int         ndig;

		// Directed strings. A lone operation opens and closes a string in the
		// same word, with reference start and read length at their upper extremes.
		str_ref = '1; str_strand = 1'b0; str_len = '1;
		push_string("M", 1'b1);
		// Clipping, match, insertion and deletion with a length, clipping both
		// before and after the match, on the same strand from reference position zero.
		str_ref = '0; str_strand = 1'b1; str_len = '0;
		push_string("2S3M2S1I2D", 1'b1);
		// Operations without a length, unknown bytes at both extremes and a
		// trailing digit on the closing word.
		str_ref = 31'd50; str_strand = 1'b0; str_len = 31'd100;
		push_string("N=X5H", 1'b0);
		add_char(8'hFF, 1'b0);
		add_char(8'h00, 1'b0);
		add_char(CH_0 + 8'd7, 1'b1);
		// A digit run long enough to saturate the pending length.
		str_ref = 31'h7FFF_FFF0; str_strand = 1'b1; str_len = 31'd1000;
		push_string("999999999X", 1'b1);

		// Random strings: mostly well-formed runs of length and operation,
		// with stray bytes, oversized runs and trailing digits mixed in.
		while (char_q.size() < 1150) begin
			body.delete();
			str_ref = rand31();
			str_strand = 1'($urandom);
			str_len = rand31();
			if ($urandom_range(19) == 0) begin
				body.push_back(8'($urandom));
			end else begin
				nops = $urandom_range(1, 6);
				for (int k = 0; k < nops; k++) begin
					if ($urandom_range(9) == 0)
						body.push_back(8'($urandom));
					ndig = ($urandom_range(29) == 0) ? $urandom_range(9, 10)
						: $urandom_range(0, 3);
					for (int d = 0; d < ndig; d++)
						body.push_back(CH_0 + 8'($urandom_range(9)));
					body.push_back(($urandom_range(19) == 0) ? 8'($urandom) : pick_op());
				end
				if ($urandom_range(9) == 0)
					body.push_back(CH_0 + 8'($urandom_range(9)));
			end
			foreach (body[i])
				add_char(body[i], i == body.size() - 1);
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (char_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (span_q.size() != 0)
			@(posedge clk);
		// Leave room for any stray output word.
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
